// ===== hdl/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sample averaging frame store package
// Shared constants and the command and status types that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package sfs_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int DIV_STEPS  = 16;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam logic [7:0] COLOR_MAX = 8'd255;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LIMIT  = 2'd2;
    localparam logic [1:0] CFG_SWAP   = 2'd3;

    typedef struct packed {
        logic clear_write;
        logic load_item;
        logic read_mem;
        logic capture;
        logic load_div;
        logic div_step;
        logic write_mem;
        logic load_out;
    } sfs_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_of_range;
    } sfs_status_t;

endpackage
`default_nettype wire

// ===== hdl/sfs_datapath.sv =====
// ----------------------------------------------------------------------------
// Sample averaging frame store datapath
// Configuration registers, pixel memory, products, four restoring dividers
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module sfs_datapath
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [8:0]           cfg_data,
    input  wire logic                 func,
    input  wire logic [7:0]           pos_x,
    input  wire logic [7:0]           pos_y,
    input  wire logic signed [15:0]   red_in,
    input  wire logic signed [15:0]   green_in,
    input  wire logic signed [15:0]   blue_in,
    input  wire sfs_pkg::sfs_cmd_t    cmd,
    output sfs_pkg::sfs_status_t      status,
    output logic                      accepted,
    output logic                      out_of_range,
    output logic [7:0]                chan0,
    output logic [7:0]                chan1,
    output logic [7:0]                chan2,
    output logic [7:0]                chan3,
    output logic [7:0]                samples_taken
);

    function automatic logic [7:0] to_level(input logic signed [15:0] v);
        logic [12:0] c;
        logic [20:0] p;
        if (v <= 16'sd0)
            c = 13'd0;
        else if (v >= 16'sd4096)
            c = 13'd4096;
        else
            c = v[12:0];
        p = {c, 8'd0} - {8'd0, c};
        return p[19:12];
    endfunction

    localparam int ADDR_W_L = sfs_pkg::ADDR_W;

    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic [7:0] limit_reg;
    logic       swap_reg;

    logic [ADDR_W_L-1:0] clr_addr_reg;

    logic [39:0] mem [sfs_pkg::DEPTH];
    logic [39:0] rdata_reg;

    logic                func_reg;
    logic                oor_reg;
    logic [ADDR_W_L-1:0] idx_reg;
    logic [7:0]          add_reg [4];
    logic [7:0]          old_reg [4];
    logic [7:0]          count_reg;
    logic [15:0]         prod_reg [4];
    logic [15:0]         quo_reg [4];
    logic [8:0]          rem_reg [4];
    logic [8:0]          dvs_reg;

    logic [8:0]  eff_w;
    logic [8:0]  eff_h;
    logic [16:0] idx_full;
    logic [7:0]  lr, lg, lb;
    logic        take;
    logic [7:0]  cnt_new;
    logic [7:0]  pix [4];
    logic [39:0] wr_word;

    assign eff_w    = (width_reg > 9'(sfs_pkg::MAX_WIDTH)) ? 9'(sfs_pkg::MAX_WIDTH) : width_reg;
    assign eff_h    = (height_reg > 9'(sfs_pkg::MAX_HEIGHT)) ? 9'(sfs_pkg::MAX_HEIGHT)
                                                            : height_reg;
    assign idx_full = eff_w * {1'b0, pos_y} + {9'd0, pos_x};
    assign lr       = to_level(red_in);
    assign lg       = to_level(green_in);
    assign lb       = to_level(blue_in);
    assign take     = !func_reg && (count_reg < limit_reg);
    assign cnt_new  = (count_reg == 8'd255) ? count_reg : count_reg + 8'd1;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            pix[k] = take ? quo_reg[k][7:0] : old_reg[k];
    end

    assign wr_word = cmd.clear_write ? {8'd0, {4{sfs_pkg::COLOR_MAX}}}
                                     : {cnt_new, pix[3], pix[2], pix[1], pix[0]};

    assign status.clear_last   = &clr_addr_reg;
    assign status.out_of_range = oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= 9'd256;
            height_reg   <= 9'd256;
            limit_reg    <= 8'd255;
            swap_reg     <= 1'b0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sfs_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                    sfs_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                    sfs_pkg::CFG_LIMIT:  limit_reg  <= cfg_data[7:0];
                    sfs_pkg::CFG_SWAP:   swap_reg   <= cfg_data[0];
                    default:             ;
                endcase
            end
            if (cmd.clear_write)
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_write || (cmd.write_mem && !func_reg))
            mem[cmd.clear_write ? clr_addr_reg : idx_reg] <= wr_word;
        if (cmd.read_mem)
            rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg   <= func;
            oor_reg    <= ({1'b0, pos_x} >= eff_w) || ({1'b0, pos_y} >= eff_h);
            idx_reg    <= idx_full[ADDR_W_L-1:0];
            add_reg[0] <= swap_reg ? lb : lr;
            add_reg[1] <= lg;
            add_reg[2] <= swap_reg ? lr : lb;
            add_reg[3] <= sfs_pkg::COLOR_MAX;
        end
        if (cmd.capture)
        begin
            count_reg <= rdata_reg[39:32];
            for (int k = 0; k < 4; k++)
            begin
                old_reg[k]  <= rdata_reg[8*k +: 8];
                prod_reg[k] <= rdata_reg[8*k +: 8] * rdata_reg[39:32];
            end
        end
        if (cmd.load_div)
        begin
            dvs_reg <= {1'b0, count_reg} + 9'd1;
            for (int k = 0; k < 4; k++)
            begin
                quo_reg[k] <= prod_reg[k] + {8'd0, add_reg[k]};
                rem_reg[k] <= 9'd0;
            end
        end
        else if (cmd.div_step)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if ({rem_reg[k], quo_reg[k][15]} >= {1'b0, dvs_reg})
                begin
                    rem_reg[k] <= 9'({rem_reg[k], quo_reg[k][15]} - {1'b0, dvs_reg});
                    quo_reg[k] <= {quo_reg[k][14:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= {rem_reg[k][7:0], quo_reg[k][15]};
                    quo_reg[k] <= {quo_reg[k][14:0], 1'b0};
                end
            end
        end
        if (cmd.load_out)
        begin
            if (oor_reg)
            begin
                accepted      <= 1'b0;
                out_of_range  <= 1'b1;
                chan0         <= 8'd0;
                chan1         <= 8'd0;
                chan2         <= 8'd0;
                chan3         <= 8'd0;
                samples_taken <= 8'd0;
            end
            else
            begin
                accepted      <= take;
                out_of_range  <= 1'b0;
                chan0         <= pix[0];
                chan1         <= pix[1];
                chan2         <= pix[2];
                chan3         <= pix[3];
                samples_taken <= func_reg ? count_reg : cnt_new;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/sfs_controller.sv =====
// ----------------------------------------------------------------------------
// Sample averaging frame store controller
// Sequences the clearing pass, the pixel read, the division steps, the
// write-back and the result handover.
// ----------------------------------------------------------------------------
`default_nettype none
module sfs_controller
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire sfs_pkg::sfs_status_t status,
    output sfs_pkg::sfs_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LOOKUP, S_FETCH, S_PREP, S_DIV, S_WRITE, S_FINISH
    } state_t;

    state_t                      state_reg, state_next;
    logic [sfs_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                if (status.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (status.out_of_range)
                    state_next = S_FINISH;
                else
                begin
                    cmd.read_mem = 1'b1;
                    state_next   = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.capture = 1'b1;
                state_next  = S_PREP;
            end
            S_PREP:
            begin
                cmd.load_div = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (&step_reg)
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write_mem = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/sample_averaging_frame_store.sv =====
// ----------------------------------------------------------------------------
// Sample averaging frame store
// Keeps a running per-pixel average of colour samples in a 64K-word store.
//
//   Channel  Handshake            Payload
//   input    in_valid/in_ready    func, pos_x, pos_y, red_in, green_in, blue_in
//   output   out_valid/out_ready  accepted, out_of_range, chan0..chan3,
//                                 samples_taken
//   config   cfg_we               cfg_index, cfg_data
//
// An in-range transaction runs a registered memory read, a product step and
// sixteen restoring division steps shared by four lanes.
// An out-of-range transaction skips the memory read, the division and the write-back.
// After reset a clearing pass writes all 65536 words, one per cycle, during
// which no input transaction is taken; configuration writes are taken.
// A stalled result is held in the output register while the next input
// transaction is already being worked on.
// ----------------------------------------------------------------------------
`default_nettype none
module sample_averaging_frame_store
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [8:0]          cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                func,
    input  wire logic [7:0]          pos_x,
    input  wire logic [7:0]          pos_y,
    input  wire logic signed [15:0]  red_in,
    input  wire logic signed [15:0]  green_in,
    input  wire logic signed [15:0]  blue_in,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     accepted,
    output logic                     out_of_range,
    output logic [7:0]               chan0,
    output logic [7:0]               chan1,
    output logic [7:0]               chan2,
    output logic [7:0]               chan3,
    output logic [7:0]               samples_taken
);

    sfs_pkg::sfs_cmd_t    cmd;
    sfs_pkg::sfs_status_t status;

    sfs_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sfs_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .func          (func),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .cmd           (cmd),
        .status        (status),
        .accepted      (accepted),
        .out_of_range  (out_of_range),
        .chan0         (chan0),
        .chan1         (chan1),
        .chan2         (chan2),
        .chan3         (chan3),
        .samples_taken (samples_taken)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a transaction is in progress");

    a_oor_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (!accepted && samples_taken == 8'd0))
        else $error("out-of-range result carries data");

    a_accept_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> (samples_taken != 8'd0 && chan3 == 8'd255))
        else $error("accepted sample with no count or wrong alpha");

endmodule
`default_nettype wire
